FILE: rtl/nirdec_pkg.sv
`timescale 1ns / 1ps

package nirdec_pkg;

    // Configuration register widths and reset values
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_W-1:0] LEADER_MIN_RST = 16'd8500;
    localparam logic [CFG_W-1:0] LEADER_MAX_RST = 16'd12500;
    localparam logic [CFG_W-1:0] ZERO_MIN_RST   = 16'd2000;
    localparam logic [CFG_W-1:0] ZERO_MAX_RST   = 16'd2500;
    localparam logic [CFG_W-1:0] ONE_MIN_RST    = 16'd4000;
    localparam logic [CFG_W-1:0] ONE_MAX_RST    = 16'd5000;

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MAX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MAX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_MIN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_MAX    = 3'd5;

    // Defaults for the top-level parameters
    localparam int FRAME_BITS_DEF     = 32;
    localparam int INTERVAL_WIDTH_DEF = 16;

    // Result fields
    localparam int STATUS_W  = 3;
    localparam int RAW_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int RESULT_W  = STATUS_W + RAW_W + 2 * BYTE_W;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Field positions inside the result tdata
    localparam int RAW_LSB  = STATUS_W;
    localparam int ADDR_LSB = RAW_LSB + RAW_W;
    localparam int KEY_LSB  = ADDR_LSB + BYTE_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOTHING    = 3'd0,
        ST_LEADER     = 3'd1,
        ST_BIT_ERROR  = 3'd2,
        ST_FRAME_GOOD = 3'd3,
        ST_FRAME_BAD  = 3'd4
    } status_t;

endpackage

FILE: rtl/nec_ir_pulse_interval_decoder_top.sv
`timescale 1ns / 1ps

// NEC-style infrared pulse-interval decoder. Each input transfer carries one
// measured edge-to-edge interval in timer ticks; each one yields exactly one
// result transfer with a status code, the received frame and its address and
// command bytes (frame fields are zero unless a frame completes). An interval
// enters an input register, is classified against the six window registers
// and updates the frame state, and the result lands in an output register:
// the block takes one interval per cycle while the output side does not stall.
// The user must write the window registers over the configuration channel only
// while no interval is in flight; the block itself does not enforce it. Windows
// are inclusive, an empty window matches nothing and an interval in both bit
// windows decodes as a zero.
module nec_ir_pulse_interval_decoder_top
#(
    parameter int FRAME_BITS     = nirdec_pkg::FRAME_BITS_DEF,
    parameter int INTERVAL_WIDTH = nirdec_pkg::INTERVAL_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Interval stream; tdata: interval [INTERVAL_WIDTH-1:0], zero pad above
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((INTERVAL_WIDTH+7)/8)*8-1:0]    s_tdata,

    // Result stream; tdata: status [2:0], raw_frame [34:3], address [42:35],
    // key_code [50:43], zero pad [55:51]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [nirdec_pkg::OUT_TDATA_W-1:0]     m_tdata,

    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [nirdec_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nirdec_pkg::CFG_W-1:0]           cfg_data
);

    import nirdec_pkg::*;

    localparam int CMP_W = (INTERVAL_WIDTH > CFG_W) ? INTERVAL_WIDTH : CFG_W;
    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam logic [CFG_W-1:0] CFG_MASK = CFG_W'({INTERVAL_WIDTH{1'b1}});

    // Window registers
    logic [CFG_W-1:0] leader_min_reg, leader_max_reg;
    logic [CFG_W-1:0] zero_min_reg, zero_max_reg;
    logic [CFG_W-1:0] one_min_reg, one_max_reg;

    // Input stage
    logic                      in_vld_reg;
    logic [INTERVAL_WIDTH-1:0] in_iv_reg;

    // Frame state
    logic                  receiving_reg, receiving_next;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;

    // Output stage
    logic                   out_vld_reg;
    logic [RESULT_W-1:0]    out_res_reg, out_res_next;

    logic advance;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_min_reg <= LEADER_MIN_RST;
            leader_max_reg <= LEADER_MAX_RST;
            zero_min_reg   <= ZERO_MIN_RST;
            zero_max_reg   <= ZERO_MAX_RST;
            one_min_reg    <= ONE_MIN_RST;
            one_max_reg    <= ONE_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEADER_MIN: leader_min_reg <= cfg_data & CFG_MASK;
                REG_LEADER_MAX: leader_max_reg <= cfg_data & CFG_MASK;
                REG_ZERO_MIN:   zero_min_reg   <= cfg_data & CFG_MASK;
                REG_ZERO_MAX:   zero_max_reg   <= cfg_data & CFG_MASK;
                REG_ONE_MIN:    one_min_reg    <= cfg_data & CFG_MASK;
                REG_ONE_MAX:    one_max_reg    <= cfg_data & CFG_MASK;
                default:        ;
            endcase
        end
    end

    // Advance the input stage whenever the output register is free or drains
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TDATA_W'(out_res_reg);

    // Capture the input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_iv_reg <= s_tdata[INTERVAL_WIDTH-1:0];
        end
    end

    // Classify the interval and update the frame state
    always_comb
    begin
        logic [CMP_W-1:0]  iv;
        logic              in_leader, in_zero, in_one;
        logic [63:0]       wide;
        logic [RAW_W-1:0]  raw;
        logic [BYTE_W-1:0] addr, addr_n, cmd, cmd_n;
        status_t           status;

        iv        = CMP_W'(in_iv_reg);
        in_leader = (iv >= CMP_W'(leader_min_reg)) && (iv <= CMP_W'(leader_max_reg));
        in_zero   = (iv >= CMP_W'(zero_min_reg)) && (iv <= CMP_W'(zero_max_reg));
        in_one    = (iv >= CMP_W'(one_min_reg)) && (iv <= CMP_W'(one_max_reg));

        receiving_next = receiving_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        status         = ST_NOTHING;
        raw            = '0;
        addr           = '0;
        cmd            = '0;
        wide           = '0;
        addr_n         = '0;
        cmd_n          = '0;

        if (!receiving_reg)
        begin
            // Idle: a leader opens a frame, anything else keeps idle
            if (in_leader)
            begin
                receiving_next = 1'b1;
                shift_next     = '0;
                status         = ST_LEADER;
            end
            bit_cnt_next = '0;
        end
        else if (in_zero || in_one)
        begin
            // Shift in the bit, first bit ends up most significant
            shift_next   = {shift_reg[FRAME_BITS-2:0], !in_zero};
            bit_cnt_next = bit_cnt_reg + CNT_W'(1);
            if (bit_cnt_next == CNT_W'(FRAME_BITS))
            begin
                receiving_next = 1'b0;
                bit_cnt_next   = '0;
                wide           = 64'(shift_next);
                raw            = wide[RAW_W-1:0];
                addr           = raw[31:24];
                addr_n         = raw[23:16];
                cmd            = raw[15:8];
                cmd_n          = raw[7:0];
                status         = ((addr == ~addr_n) && (cmd == ~cmd_n)) ?
                                 ST_FRAME_GOOD : ST_FRAME_BAD;
            end
        end
        else
        begin
            // Drop the frame on an out-of-window interval
            receiving_next = 1'b0;
            bit_cnt_next   = '0;
            shift_next     = '0;
            status         = ST_BIT_ERROR;
        end

        out_res_next = {cmd, addr, raw, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                receiving_reg <= receiving_next;
                bit_cnt_reg   <= bit_cnt_next;
                shift_reg     <= shift_next;
                out_vld_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

endmodule

FILE: rtl/nirdec_checker.sv
`timescale 1ns / 1ps

module nirdec_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [nirdec_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import nirdec_pkg::*;

    logic [STATUS_W-1:0] status;
    logic [RAW_W-1:0]    raw;
    logic [BYTE_W-1:0]   addr;
    logic [BYTE_W-1:0]   key;
    logic                done;
    logic                frame_ok;

    assign status   = m_tdata[STATUS_W-1:0];
    assign raw      = m_tdata[RAW_LSB +: RAW_W];
    assign addr     = m_tdata[ADDR_LSB +: BYTE_W];
    assign key      = m_tdata[KEY_LSB +: BYTE_W];
    assign done     = (status == ST_FRAME_GOOD) || (status == ST_FRAME_BAD);
    assign frame_ok = (raw[31:24] == ~raw[23:16]) && (raw[15:8] == ~raw[7:0]);

    // Hold a stalled result transfer
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Frame fields stay zero unless a frame completes
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !done |-> raw == '0 && addr == '0 && key == '0)
        else $error("frame fields set without a completed frame");

    // Address and command bytes come from the reported frame
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && done |-> addr == raw[31:24] && key == raw[15:8])
        else $error("address or command byte does not match the frame");

    // Good and failed frames agree with the complement check
    a_check: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && done |-> (status == ST_FRAME_GOOD) == frame_ok)
        else $error("frame check status wrong");

endmodule

bind nec_ir_pulse_interval_decoder_top nirdec_checker u_nirdec_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/nec_ir_pulse_interval_decoder_top_tb.sv
`timescale 1ns / 1ps

module nec_ir_pulse_interval_decoder_top_tb;

    import nirdec_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int IV_W         = INTERVAL_WIDTH_DEF;
    localparam int FRAME_LEN    = FRAME_BITS_DEF;

    // Indexes past the last window register; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_ONE_MAX + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = REG_ONE_MAX + 3'd2;

    typedef enum logic [1:0] {
        OP_INTERVAL,
        OP_CFG,
        OP_HOLD
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_W-1:0]       value;
    } stim_op_t;

    typedef struct packed {
        status_t           status;
        logic [RAW_W-1:0]  raw_frame;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] key_code;
    } frame_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IV_W-1:0]        s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // Stimulus and scoreboard
    stim_op_t      pending_ops[$];
    frame_result_t expected_results[$];
    int            gen_win[0:5];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            idle_cycles    = 0;
    logic          in_taken       = 1'b0;
    logic          cfg_taken      = 1'b0;

    // Decoder shadow: window registers and frame state
    logic [CFG_W-1:0]     window_reg[0:5];
    logic                 rx_active;
    int                   rx_bits;
    logic [FRAME_LEN-1:0] rx_word;

    nec_ir_pulse_interval_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic in_window(logic [CFG_W-1:0] v, logic [CFG_W-1:0] lo,
                                       logic [CFG_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    task automatic write_window(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
        if (idx <= REG_ONE_MAX)
            window_reg[idx] = value;
    endtask

    // Classify one interval and advance the shadow frame state
    function automatic frame_result_t decode_interval(logic [IV_W-1:0] iv);
        frame_result_t     r;
        logic              hit_zero;
        logic              hit_one;
        logic [BYTE_W-1:0] a, ac, c, cc;
        r.status    = ST_NOTHING;
        r.raw_frame = '0;
        r.address   = '0;
        r.key_code  = '0;
        if (!rx_active)
        begin
            if (in_window(iv, window_reg[REG_LEADER_MIN], window_reg[REG_LEADER_MAX]))
            begin
                rx_active = 1'b1;
                rx_word   = '0;
                r.status  = ST_LEADER;
            end
            rx_bits = 0;
        end
        else
        begin
            hit_zero = in_window(iv, window_reg[REG_ZERO_MIN], window_reg[REG_ZERO_MAX]);
            hit_one  = in_window(iv, window_reg[REG_ONE_MIN], window_reg[REG_ONE_MAX]);
            if (hit_zero || hit_one)
            begin
                // zero wins where the bit windows overlap
                rx_word = {rx_word[FRAME_LEN-2:0], !hit_zero};
                rx_bits++;
                if (rx_bits >= FRAME_LEN)
                begin
                    rx_active   = 1'b0;
                    rx_bits     = 0;
                    r.raw_frame = rx_word[RAW_W-1:0];
                    a  = r.raw_frame[31:24];
                    ac = r.raw_frame[23:16];
                    c  = r.raw_frame[15:8];
                    cc = r.raw_frame[7:0];
                    r.address  = a;
                    r.key_code = c;
                    r.status   = (a == ~ac && c == ~cc) ? ST_FRAME_GOOD : ST_FRAME_BAD;
                end
            end
            else
            begin
                rx_active = 1'b0;
                rx_bits   = 0;
                rx_word   = '0;
                r.status  = ST_BIT_ERROR;
            end
        end
        return r;
    endfunction

    // Idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stimulus building
    task automatic add_interval(int v);
        stim_op_t op;
        op.kind  = OP_INTERVAL;
        op.idx   = '0;
        op.value = v[CFG_W-1:0];
        pending_ops.push_back(op);
    endtask

    task automatic add_cfg(logic [CFG_INDEX_W-1:0] idx, int v);
        stim_op_t op;
        op.kind  = OP_CFG;
        op.idx   = idx;
        op.value = v[CFG_W-1:0];
        pending_ops.push_back(op);
        if (idx <= REG_ONE_MAX)
            gen_win[idx] = v;
    endtask

    task automatic add_hold();
        stim_op_t op;
        op.kind  = OP_HOLD;
        op.idx   = '0;
        op.value = '0;
        pending_ops.push_back(op);
    endtask

    task automatic set_windows(int lmin, int lmax, int zmin, int zmax, int omin, int omax);
        add_cfg(REG_LEADER_MIN, lmin);
        add_cfg(REG_LEADER_MAX, lmax);
        add_cfg(REG_ZERO_MIN, zmin);
        add_cfg(REG_ZERO_MAX, zmax);
        add_cfg(REG_ONE_MIN, omin);
        add_cfg(REG_ONE_MAX, omax);
    endtask

    // Value inside a window, edges favored; anything for an empty window
    function automatic int pick_in(int lo, int hi);
        int r;
        if (lo > hi)
            return $urandom_range(0, 65535);
        r = $urandom_range(0, 3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int pick_noise();
        int r;
        int v;
        r = $urandom_range(0, 3);
        if (r == 2)
        begin
            v = gen_win[$urandom_range(0, 5)] + ($urandom_range(0, 1) ? 1 : -1);
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            return v;
        end
        if (r == 3)
            return $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(65520, 65535);
        return $urandom_range(0, 65535);
    endfunction

    // Leader plus 32 bit intervals, first bit from the MSB; optionally cut short
    task automatic add_frame(logic [31:0] bits, int break_at);
        add_interval(pick_in(gen_win[REG_LEADER_MIN], gen_win[REG_LEADER_MAX]));
        for (int i = 31; i >= 0; i--)
        begin
            if (i == break_at)
            begin
                add_interval(pick_noise());
                return;
            end
            if (bits[i])
                add_interval(pick_in(gen_win[REG_ONE_MIN], gen_win[REG_ONE_MAX]));
            else
                add_interval(pick_in(gen_win[REG_ZERO_MIN], gen_win[REG_ZERO_MAX]));
        end
    endtask

    task automatic add_random_run(int n);
        int          count;
        int          brk;
        int          r;
        int          k;
        logic        held;
        logic [7:0]  a, c;
        logic [31:0] bits;
        count = 0;
        held  = 1'b0;
        while (count < n)
        begin
            if (!held && count >= n / 2)
            begin
                add_hold();
                held = 1'b1;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                a = 8'($urandom);
                c = 8'($urandom);
                r = $urandom_range(0, 19);
                if (r < 10)
                    bits = {a, ~a, c, ~c};
                else if (r < 17)
                    bits = $urandom;
                else
                    bits = {a, ~a, c, ~c} ^ (32'd1 << $urandom_range(0, 31));
                brk = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : -1;
                add_frame(bits, brk);
                count += 33;
            end
            else
            begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                    add_interval(pick_noise());
                count += k;
            end
        end
    endtask

    // Sender: one transfer or register write at a time, random gaps
    int send_gap  = 0;
    int calm_send = 0;

    always @(negedge clk)
    begin : send_proc
        stim_op_t op;
        logic     next_s_valid;
        logic     next_cfg_valid;
        logic     advance;
        if (rst_n && !((s_tvalid && !in_taken) || (cfg_valid && !cfg_taken)))
        begin
            next_s_valid   = 1'b0;
            next_cfg_valid = 1'b0;
            advance        = 1'b0;
            if (send_gap != 0)
                send_gap--;
            else if (pending_ops.size() != 0)
            begin
                op = pending_ops[0];
                case (op.kind)
                    OP_INTERVAL:
                    begin
                        void'(pending_ops.pop_front());
                        next_s_valid = 1'b1;
                        s_tdata <= op.value[IV_W-1:0];
                        advance = 1'b1;
                    end
                    OP_CFG:
                    begin
                        // write only with nothing in flight
                        if (expected_results.size() == 0 && idle_cycles >= DRAIN_CYCLES)
                        begin
                            void'(pending_ops.pop_front());
                            next_cfg_valid = 1'b1;
                            cfg_index <= op.idx;
                            cfg_data  <= op.value;
                            advance = 1'b1;
                        end
                    end
                    default:
                    begin
                        // hold off until every result is back
                        if (expected_results.size() == 0)
                        begin
                            void'(pending_ops.pop_front());
                            advance = 1'b1;
                        end
                    end
                endcase
                if (advance)
                begin
                    if (calm_send != 0)
                    begin
                        calm_send--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 39) == 0)
                            calm_send = $urandom_range(20, 80);
                    end
                end
            end
            s_tvalid  <= next_s_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // Receiver: stall the result stream at random
    int stall_left = 0;
    int calm_recv  = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (calm_recv != 0)
                calm_recv--;
            else
            begin
                stall_left = pick_gap();
                if ($urandom_range(0, 39) == 0)
                    calm_recv = $urandom_range(20, 80);
            end
        end
    end

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge clk)
    begin : watch_proc
        frame_result_t     want;
        logic [2:0]        got_status;
        logic [RAW_W-1:0]  got_raw;
        logic [BYTE_W-1:0] got_addr;
        logic [BYTE_W-1:0] got_key;
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nec_ir_pulse_interval_decoder_top_tb NOT OK");
            $finish;
        end
        else
        begin
            cycle_count++;
            in_taken  <= s_tvalid && s_tready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
                write_window(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                expected_results.push_back(decode_interval(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got_status = m_tdata[STATUS_W-1:0];
                got_raw    = m_tdata[RAW_LSB +: RAW_W];
                got_addr   = m_tdata[ADDR_LSB +: BYTE_W];
                got_key    = m_tdata[KEY_LSB +: BYTE_W];
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result status %0d with none expected",
                                              got_status));
                else
                begin
                    want = expected_results.pop_front();
                    if (got_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got_status, want.status));
                    if (got_raw !== want.raw_frame)
                        report_mismatch($sformatf("raw_frame %h, want %h",
                                                  got_raw, want.raw_frame));
                    if (got_addr !== want.address)
                        report_mismatch($sformatf("address %h, want %h",
                                                  got_addr, want.address));
                    if (got_key !== want.key_code)
                        report_mismatch($sformatf("key_code %h, want %h",
                                                  got_key, want.key_code));
                end
            end
            if (expected_results.size() == 0)
                idle_cycles++;
            else
                idle_cycles = 0;
        end
    end

    initial
    begin
        // Shadow state after reset
        window_reg[REG_LEADER_MIN] = LEADER_MIN_RST;
        window_reg[REG_LEADER_MAX] = LEADER_MAX_RST;
        window_reg[REG_ZERO_MIN]   = ZERO_MIN_RST;
        window_reg[REG_ZERO_MAX]   = ZERO_MAX_RST;
        window_reg[REG_ONE_MIN]    = ONE_MIN_RST;
        window_reg[REG_ONE_MAX]    = ONE_MAX_RST;
        rx_active = 1'b0;
        rx_bits   = 0;
        rx_word   = '0;
        for (int i = 0; i <= 5; i++)
            gen_win[i] = window_reg[i];

        // Directed: idle extremes, leader edges, each bit-window edge and abort
        add_interval(0);
        add_interval(65535);
        add_interval(LEADER_MIN_RST - 1);
        add_interval(LEADER_MAX_RST + 1);
        add_interval(LEADER_MIN_RST);
        add_interval(ZERO_MIN_RST - 1);
        add_interval(LEADER_MAX_RST);
        add_interval(ZERO_MAX_RST + 1);
        add_interval(LEADER_MIN_RST);
        add_interval(ONE_MIN_RST - 1);
        add_interval(LEADER_MIN_RST);
        add_interval(ONE_MAX_RST + 1);
        add_interval(LEADER_MIN_RST);
        add_interval(LEADER_MAX_RST);
        add_interval(LEADER_MIN_RST);
        add_interval(ZERO_MIN_RST);
        add_interval(ZERO_MAX_RST);
        add_interval(ONE_MIN_RST);
        add_interval(ONE_MAX_RST);
        add_interval(65535);

        // Reset windows: extreme frames, then random traffic
        add_frame(32'h00FF00FF, -1);
        add_frame(32'hFF00FF00, -1);
        add_frame(32'hFFFFFFFF, -1);
        add_frame(32'h00000000, -1);
        add_random_run(100);

        // Narrow windows at both ends of the range
        set_windows(65000, 65535, 0, 10, 11, 40);
        add_random_run(80);

        // Leader window overlapping both bit windows, bit windows overlapping
        set_windows(2500, 4000, 1000, 3000, 2000, 5000);
        add_random_run(80);

        // Leader matches everything, zero window empty
        set_windows(0, 65535, 3000, 2000, 500, 600);
        add_random_run(70);

        // Leader window empty, bit windows full range
        set_windows(65535, 0, 0, 65535, 0, 65535);
        add_random_run(30);

        // Writes past the last register, then the reset windows again
        add_cfg(REG_SPARE_LO, $urandom_range(0, 65535));
        add_cfg(REG_SPARE_HI, $urandom_range(0, 65535));
        set_windows(LEADER_MIN_RST, LEADER_MAX_RST, ZERO_MIN_RST, ZERO_MAX_RST,
                    ONE_MIN_RST, ONE_MAX_RST);
        add_random_run(90);

        // Reset, released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: all stimulus out, every result back
        while (pending_ops.size() != 0 || s_tvalid || cfg_valid
               || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("nec_ir_pulse_interval_decoder_top_tb OK");
        else
            $display("nec_ir_pulse_interval_decoder_top_tb NOT OK");
        $finish;
    end

endmodule
